FILE: rtl/core/bbsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded byte stream FIFO.
// No dependencies; imported by every module of the block.
package bbsf_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 13;
    localparam int TOTAL_W       = 32;
    localparam int CMD_W         = 2;
    localparam int DEPTH_DEFAULT = 4096;
    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(DEPTH_DEFAULT);

    // push_byte and pop_count, padded to whole bytes
    localparam int S_TDATA_W = 24;
    // all result fields, padded to whole bytes
    localparam int M_TDATA_W = 104;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLOSE = 2'd2
    } bbsf_cmd_t;

    // Status of one item as it leaves the control stage.
    typedef struct packed {
        logic               head_valid;
        logic               push_accepted;
        logic [LEN_W-1:0]   buffered_count;
        logic [LEN_W-1:0]   free_space;
        logic [TOTAL_W-1:0] total_pushed;
        logic [TOTAL_W-1:0] total_popped;
        logic               stream_closed;
        logic               stream_finished;
    } bbsf_status_t;

endpackage

FILE: rtl/core/bbsf_ram.sv
`timescale 1ns / 1ps
// Byte store: simple dual-port synchronous RAM, read-first, with a registered read port.
// Depends on bbsf_pkg for the byte width.
module bbsf_ram
    import bbsf_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] byte_store [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byte_store[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next enabled read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= byte_store[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/bbsf_ctrl.sv
`timescale 1ns / 1ps
// Pointer, fill and total bookkeeping; issues the RAM write and the head read.
// Depends on bbsf_pkg for the command codes and the status struct.
module bbsf_ctrl
    import bbsf_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_accept,
    input  bbsf_cmd_t         item_cmd,
    input  logic [LEN_W-1:0]  item_count,
    input  logic [LEN_W-1:0]  capacity_limit,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [ADDR_W-1:0] ram_rd_addr,
    output logic              head_forward,
    output bbsf_status_t      status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [TOTAL_W-1:0] pushed_reg, pushed_next;
    logic [TOTAL_W-1:0] popped_reg, popped_next;
    logic               closed_reg, closed_next;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] pop_n;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] wr_inc;
    logic             push_ok;
    logic [CNT_W-1:0] room;

    // Limits above the store depth saturate at the depth.
    assign limit = (CMP_W'(capacity_limit) > DEPTH_C) ? CNT_W'(DEPTH)
                                                     : CNT_W'(capacity_limit);
    assign pop_n = (CMP_W'(item_count) > CMP_W'(held_reg)) ? held_reg
                                                          : CNT_W'(item_count);
    assign push_ok = item_accept && (item_cmd == CMD_PUSH) && !closed_reg
                     && (held_reg < limit);

    assign rd_sum = SUM_W'(rd_ptr_reg) + SUM_W'(pop_n);
    assign wr_inc = SUM_W'(wr_ptr_reg) + SUM_W'(1);

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        held_next   = held_reg;
        pushed_next = pushed_reg;
        popped_next = popped_reg;
        closed_next = closed_reg;
        if (item_accept) begin
            case (item_cmd)
                CMD_PUSH: begin
                    if (push_ok) begin
                        wr_ptr_next = (wr_inc == DEPTH_S) ? '0 : ADDR_W'(wr_inc);
                        held_next   = held_reg + CNT_W'(1);
                        pushed_next = pushed_reg + TOTAL_W'(1);
                    end
                end
                CMD_POP: begin
                    rd_ptr_next = (rd_sum >= DEPTH_S) ? ADDR_W'(rd_sum - DEPTH_S)
                                                      : ADDR_W'(rd_sum);
                    held_next   = held_reg - pop_n;
                    popped_next = popped_reg + TOTAL_W'(pop_n);
                end
                CMD_CLOSE: begin
                    closed_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            held_reg   <= '0;
            pushed_reg <= '0;
            popped_reg <= '0;
            closed_reg <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            held_reg   <= held_next;
            pushed_reg <= pushed_next;
            popped_reg <= popped_next;
            closed_reg <= closed_next;
        end
    end

    assign ram_wr_en   = push_ok;
    assign ram_wr_addr = wr_ptr_reg;
    assign ram_rd_addr = rd_ptr_next;
    // The RAM reads old data on a same-address write, so the new byte is forwarded.
    assign head_forward = push_ok && (rd_ptr_next == wr_ptr_reg);

    assign room = (held_next >= limit) ? '0 : (limit - held_next);

    always_comb begin
        status.head_valid      = (held_next != '0);
        status.push_accepted   = push_ok;
        status.buffered_count  = LEN_W'(held_next);
        status.free_space      = LEN_W'(room);
        status.total_pushed    = pushed_next;
        status.total_popped    = popped_next;
        status.stream_closed   = closed_next;
        status.stream_finished = closed_next && (held_next == '0);
    end

endmodule

FILE: rtl/core/bounded_byte_stream_fifo.sv
`timescale 1ns / 1ps
// Bounded byte stream FIFO with writer-side close: top level.
// Results pass through a stage-one register and an output register.
// Throughput: one item per cycle while the result channel is not stalled; the
// head byte comes from one synchronous RAM read port, with forwarding.
// Reset (aresetn, synchronous, active low) clears pointers, fill, totals,
// the closed flag and the limit (to DEPTH_DEFAULT); the RAM is not cleared.
module bounded_byte_stream_fifo
    import bbsf_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] push_byte, [20:8] pop_count, [23:21] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_tuser,
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] head_byte, [8] head_valid, [9] push_accepted, [22:10] buffered_count,
    // [35:23] free_space, [67:36] total_pushed, [99:68] total_popped,
    // [100] stream_closed, [101] stream_finished, [103:102] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration channel: capacity_limit.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LEN_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    logic [LEN_W-1:0] cap_limit_reg;

    logic              item_accept;
    bbsf_cmd_t         item_cmd;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;
    logic              head_forward;
    bbsf_status_t      ctrl_status;

    // Stage one: the RAM read is in flight.
    logic              s1_valid_reg, s1_valid_next;
    bbsf_status_t      s1_status_reg;
    logic              s1_fwd_reg;
    logic [BYTE_W-1:0] s1_fwd_byte_reg;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_load;
    logic [BYTE_W-1:0]    head_byte;

    // The configuration register is always ready; the user must write it only while idle (not enforced by the block).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_limit_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_limit_reg <= cfg_data;
        end
    end

    // Stage one moves on whenever the output register is empty or being drained,
    // and a new transfer is taken whenever stage one is empty or moving on.
    assign out_load    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !s1_valid_reg || out_load;
    assign item_accept = s_tvalid && s_tready;
    assign item_cmd    = bbsf_cmd_t'(s_tuser);

    bbsf_ctrl #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_accept    (item_accept),
        .item_cmd       (item_cmd),
        .item_count     (s_tdata[20:8]),
        .capacity_limit (cap_limit_reg),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_rd_addr    (ram_rd_addr),
        .head_forward   (head_forward),
        .status         (ctrl_status)
    );

    bbsf_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata[7:0]),
        .rd_en   (item_accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (item_accept) begin
            s1_valid_next = 1'b1;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one payload; the RAM data register holds alongside it, since no
    // new read is issued until stage one moves on.
    always_ff @(posedge aclk) begin
        if (item_accept) begin
            s1_status_reg   <= ctrl_status;
            s1_fwd_reg      <= head_forward;
            s1_fwd_byte_reg <= s_tdata[7:0];
        end
    end

    // An empty buffer reports a zero head byte.
    always_comb begin
        if (!s1_status_reg.head_valid) begin
            head_byte = '0;
        end else if (s1_fwd_reg) begin
            head_byte = s1_fwd_byte_reg;
        end else begin
            head_byte = ram_rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {2'b00,
                             s1_status_reg.stream_finished,
                             s1_status_reg.stream_closed,
                             s1_status_reg.total_popped,
                             s1_status_reg.total_pushed,
                             s1_status_reg.free_space,
                             s1_status_reg.buffered_count,
                             s1_status_reg.push_accepted,
                             s1_status_reg.head_valid,
                             head_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A stalled result channel must freeze stage one with its status intact.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_tready)
            |=> (s1_valid_reg && $stable(s1_status_reg)))
        else $error("stage one changed while the output was stalled");

    // A finished stream never reports a valid head byte.
    a_finished_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[101] && m_tdata[8]))
        else $error("finished stream reports buffered data");

    // A stored byte leaves at least one byte buffered.
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_status_reg.push_accepted) |-> s1_status_reg.head_valid)
        else $error("accepted push left the buffer empty");

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

endmodule
